@@ hdl/wtb_pkg.sv @@
package wtb_pkg;

  // field widths of the streams and registers
  localparam int unsigned CoordW = 12;
  localparam int unsigned DimW   = 13;
  localparam int unsigned PosW   = 15;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned AddrW  = 24;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SCALE_LEVELS  = 2'd0;
  localparam logic [1:0] REG_IMAGE_COLUMNS = 2'd1;
  localparam logic [1:0] REG_IMAGE_ROWS    = 2'd2;

  // detail subband order within one row and column position
  localparam logic [1:0] SUB_LL = 2'd0;
  localparam logic [1:0] SUB_LR = 2'd1;
  localparam logic [1:0] SUB_UR = 2'd2;

  // sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COARSE,
    PH_DETAIL
  } phase_e;

  // one address pair before the row multiply
  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic [IdxW-1:0] idx;
    logic            last;
  } pair_t;

endpackage

@@ hdl/wtb_seq.sv @@
module wtb_seq
  import wtb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CoordW-1:0] in_x_i,
  input  logic [CoordW-1:0] in_y_i,
  input  logic [1:0]        sc_i,
  input  logic [DimW-1:0]   bx_i,
  input  logic [DimW-1:0]   by_i,
  output logic              pair_valid_o,
  output pair_t             pair_o,
  input  logic              pair_ready_i
);

  // one-item input buffer
  logic              buf_valid_q, buf_valid_d;
  logic [CoordW-1:0] buf_x_q, buf_y_q;

  // walk state
  phase_e            phase_q, phase_d;
  logic [CoordW-1:0] lx_q, lx_d, ly_q, ly_d;
  logic [1:0]        lvl_q, lvl_d, row_q, row_d, col_q, col_d, sub_q, sub_d;

  // pair stage register
  logic              a_valid_q, a_valid_d;
  pair_t             a_pair_q, a_pair_d;

  logic              adv, load, in_acc;
  logic [1:0]        size_m1, sc_m1;
  logic [PosW-1:0]   x0, y0, bw, bh;
  pair_t             cur;

  // the buffer also takes an item in the cycle it hands its own to the walk
  assign in_ready_o   = !buf_valid_q || load;
  assign in_acc       = in_valid_i && in_ready_o;
  assign adv          = !a_valid_q || pair_ready_i;
  assign pair_valid_o = a_valid_q;
  assign pair_o       = a_pair_q;

  // level geometry
  assign size_m1 = 2'((3'd1 << lvl_q) - 3'd1);
  assign sc_m1   = sc_i - 2'd1;
  assign x0      = PosW'(lx_q) << lvl_q;
  assign y0      = PosW'(ly_q) << lvl_q;
  assign bw      = PosW'(bx_i) << lvl_q;
  assign bh      = PosW'(by_i) << lvl_q;

  // current pair from the walk position
  always_comb begin
    cur = '0;
    unique case (phase_q)
      PH_COARSE: begin
        cur.row  = PosW'(ly_q);
        cur.col  = PosW'(lx_q);
        cur.idx  = '0;
        cur.last = (sc_i == 2'd0);
      end
      PH_DETAIL: begin
        cur.row  = (sub_q == SUB_UR) ? (y0 + PosW'(row_q)) : (y0 + bh + PosW'(row_q));
        cur.col  = (sub_q == SUB_LL) ? (x0 + PosW'(col_q)) : (x0 + bw + PosW'(col_q));
        cur.idx  = IdxW'((IdxW'(sub_q) + IdxW'(1)) << {lvl_q, 1'b0})
                 + IdxW'(IdxW'(row_q) << lvl_q) + IdxW'(col_q);
        cur.last = (lvl_q == sc_m1) && (row_q == size_m1) && (col_q == size_m1)
                 && (sub_q == SUB_UR);
      end
      default: cur = '0;
    endcase
  end

  assign load = buf_valid_q && ((phase_q == PH_IDLE) || (adv && cur.last));

  // next walk state
  always_comb begin
    phase_d = phase_q;
    lx_d    = lx_q;
    ly_d    = ly_q;
    lvl_d   = lvl_q;
    row_d   = row_q;
    col_d   = col_q;
    sub_d   = sub_q;
    if (load) begin
      phase_d = PH_COARSE;
      lx_d    = buf_x_q;
      ly_d    = buf_y_q;
      lvl_d   = '0;
      row_d   = '0;
      col_d   = '0;
      sub_d   = SUB_LL;
    end else if (adv) begin
      unique case (phase_q)
        PH_IDLE: phase_d = PH_IDLE;
        PH_COARSE: begin
          phase_d = cur.last ? PH_IDLE : PH_DETAIL;
          lvl_d   = '0;
          row_d   = '0;
          col_d   = '0;
          sub_d   = SUB_LL;
        end
        PH_DETAIL: begin
          if (cur.last) begin
            phase_d = PH_IDLE;
          end else if (sub_q != SUB_UR) begin
            sub_d = sub_q + 2'd1;
          end else begin
            sub_d = SUB_LL;
            if (col_q != size_m1) begin
              col_d = col_q + 2'd1;
            end else begin
              col_d = '0;
              if (row_q != size_m1) begin
                row_d = row_q + 2'd1;
              end else begin
                row_d = '0;
                lvl_d = lvl_q + 2'd1;
              end
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // buffer and pair stage next values
  always_comb begin
    buf_valid_d = (buf_valid_q && !load) || in_acc;
    a_valid_d   = a_valid_q;
    a_pair_d    = a_pair_q;
    if (adv) begin
      a_valid_d = (phase_q != PH_IDLE);
      a_pair_d  = cur;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      a_valid_q   <= 1'b0;
      lvl_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      sub_q       <= SUB_LL;
    end else begin
      buf_valid_q <= buf_valid_d;
      phase_q     <= phase_d;
      a_valid_q   <= a_valid_d;
      lvl_q       <= lvl_d;
      row_q       <= row_d;
      col_q       <= col_d;
      sub_q       <= sub_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_x_q <= in_x_i;
      buf_y_q <= in_y_i;
    end
    lx_q     <= lx_d;
    ly_q     <= ly_d;
    a_pair_q <= a_pair_d;
  end

endmodule

@@ hdl/wtb_addr.sv @@
module wtb_addr
  import wtb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pair_valid_i,
  input  pair_t            pair_i,
  output logic             pair_ready_o,
  input  logic [DimW-1:0]  cols_i,
  output logic             out_valid_o,
  output logic [IdxW-1:0]  out_idx_o,
  output logic [AddrW-1:0] out_addr_o,
  output logic             out_last_o,
  input  logic             out_ready_i
);

  localparam int unsigned ProdW = DimW + PosW;

  logic             out_valid_q, out_valid_d;
  logic [IdxW-1:0]  idx_q;
  logic [AddrW-1:0] addr_q;
  logic             last_q;
  logic [ProdW-1:0] lin;

  assign pair_ready_o = !out_valid_q || out_ready_i;

  // row times columns plus column, wrapped to the address width
  assign lin = ProdW'(cols_i) * ProdW'(pair_i.row) + ProdW'(pair_i.col);

  assign out_valid_d = pair_ready_o ? pair_valid_i : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (pair_ready_o) begin
      idx_q  <= pair_i.idx;
      addr_q <= lin[AddrW-1:0];
      last_q <= pair_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_idx_o   = idx_q;
  assign out_addr_o  = addr_q;
  assign out_last_o  = last_q;

endmodule

@@ hdl/wavelet_tree_block_address_gen_top.sv @@
// Wavelet tree gather address generator.
// Slave stream: one item per tree, tdata holds block_x and block_y, the block
// coordinate in the coarsest band. Master stream: the address pairs that
// gather that tree, tree_index and image_address in tdata, tlast on the final
// pair. The first pair is the coarse coefficient, then the detail pairs level
// by level, row, column, and lower left, lower right, upper right subband.
// An item gives 4^levels pairs (1, 4, 16 or 64); the walk sequencer emits
// one pair per cycle while the receiver does not stall, and blocks follow
// one another with no gap when the next item waits in the buffer.
// Items run through the input buffer, walk state, pair stage and multiply stage.
// A one-item input buffer takes the next coordinate while a block is still
// running or a result waits to be taken.
// APB registers: scale_levels at 0x0, image_columns at 0x4, image_rows at 0x8;
// the user must write them only while the block is idle; the block does not enforce it.
// Reset empties the buffer and the pipeline and sets 3 levels, 512 by 512.
// When the receiver stalls, the result register holds its pair and the
// walk waits; nothing is dropped.
module wavelet_tree_block_address_gen_top
  import wtb_pkg::*;
#(
  parameter int unsigned MAX_SCALES  = 3,
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // block_x [11:0], block_y [23:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // tree_index [5:0], image_address [29:6], zero [31:30]
  output logic        m_axis_tlast,  // last_pair
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]       scale_q, scale_d;
  logic [DimW-1:0]  cols_q, cols_d, rows_q, rows_d;
  logic [1:0]       reg_idx;
  logic             wr_en;
  logic [1:0]       sc;
  logic [DimW-1:0]  cols_sat, bx, by;
  logic             pair_valid, pair_ready;
  pair_t            pair;
  logic [IdxW-1:0]  out_idx;
  logic [AddrW-1:0] out_addr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_comb begin
    scale_d = scale_q;
    cols_d  = cols_q;
    rows_d  = rows_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SCALE_LEVELS:  scale_d = pwdata[1:0];
        REG_IMAGE_COLUMNS: cols_d  = pwdata[DimW-1:0];
        REG_IMAGE_ROWS:    rows_d  = pwdata[DimW-1:0];
        default:           ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_SCALE_LEVELS:  prdata = 32'(scale_q);
      REG_IMAGE_COLUMNS: prdata = 32'(cols_q);
      REG_IMAGE_ROWS:    prdata = 32'(rows_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 2'd3;
      cols_q  <= 13'd512;
      rows_q  <= 13'd512;
    end else begin
      scale_q <= scale_d;
      cols_q  <= cols_d;
      rows_q  <= rows_d;
    end
  end

  // saturated geometry and coarse band size
  assign sc       = (32'(scale_q) > MAX_SCALES) ? 2'(MAX_SCALES) : scale_q;
  assign cols_sat = (32'(cols_q) > MAX_COLUMNS) ? DimW'(MAX_COLUMNS) : cols_q;
  assign bx       = cols_sat >> sc;
  assign by       = rows_q >> sc;

  wtb_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_x_i       (s_axis_tdata[11:0]),
    .in_y_i       (s_axis_tdata[23:12]),
    .sc_i         (sc),
    .bx_i         (bx),
    .by_i         (by),
    .pair_valid_o (pair_valid),
    .pair_o       (pair),
    .pair_ready_i (pair_ready)
  );

  wtb_addr u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_valid_i (pair_valid),
    .pair_i       (pair),
    .pair_ready_o (pair_ready),
    .cols_i       (cols_sat),
    .out_valid_o  (m_axis_tvalid),
    .out_idx_o    (out_idx),
    .out_addr_o   (out_addr),
    .out_last_o   (m_axis_tlast),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, out_addr, out_idx};

endmodule

@@ hdl/wtb_checker.sv @@
module wtb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic       in_acc, out_acc;
  logic       after_last_q;
  logic [2:0] open_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // blocks taken but not finished, and whether the next pair starts a block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_last_q <= 1'b1;
      open_q       <= '0;
    end else begin
      if (out_acc) begin
        after_last_q <= m_axis_tlast;
      end
      open_q <= open_q + 3'(in_acc) - 3'(out_acc && m_axis_tlast);
    end
  end

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // every block opens with the coarse pair at tree index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && after_last_q |-> m_axis_tdata[5:0] == 6'd0)
    else $error("block does not start at tree index zero");

  // no result without an open block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> open_q != 3'd0)
    else $error("result with no block outstanding");

endmodule

bind wavelet_tree_block_address_gen_top wtb_checker u_wtb_checker (.*);

@@ bench/tree_address_checker.sv @@
module tree_address_checker
  import wtb_pkg::*;
#(
  parameter int unsigned MAX_SCALES  = 3,
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // block_x [11:0], block_y [23:12]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // tree_index [5:0], image_address [29:6], zero [31:30]
  input  logic        m_axis_tlast,   // last_pair
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned pending_o,
  output int unsigned error_count_o
);

  typedef struct {
    logic [IdxW-1:0]  tree_index;
    logic [AddrW-1:0] image_address;
    logic             last_pair;
  } addr_pair_t;

  // shadow registers, same reset as the block
  logic [1:0]      levels_q;
  logic [DimW-1:0] columns_q;
  logic [DimW-1:0] rows_q;

  addr_pair_t  expected_pairs[$];
  int unsigned error_count;

  assign pending_o     = expected_pairs.size();
  assign error_count_o = error_count;

  // queue one address pair
  function automatic void push_pair(int unsigned idx, logic [63:0] addr, logic last);
    addr_pair_t p;
    p.tree_index    = idx[IdxW-1:0];
    p.image_address = addr[AddrW-1:0];
    p.last_pair     = last;
    expected_pairs.push_back(p);
  endfunction

  // every pair of one tree, coarse coefficient first
  function automatic void predict_tree_pairs(logic [CoordW-1:0] bx, logic [CoordW-1:0] by);
    int unsigned lv, sz, sq, offset, k, j, i, sb;
    logic [63:0] cols, band_w, band_h, row, col;
    logic        last;
    lv = levels_q;
    if (lv > MAX_SCALES) lv = MAX_SCALES;
    cols = (columns_q > MAX_COLUMNS) ? 64'(MAX_COLUMNS) : 64'(columns_q);
    push_pair(0, cols * by + bx, lv == 0);
    offset = 1;
    sz = 1;
    for (k = 0; k < lv; k++) begin
      sq = sz * sz;
      band_w = (cols >> lv) * sz;
      band_h = (64'(rows_q) >> lv) * sz;
      for (j = 0; j < sz; j++) begin
        for (i = 0; i < sz; i++) begin
          for (sb = SUB_LL; sb <= SUB_UR; sb++) begin
            // upper right stays on the coarse rows, the lower bands drop by a band height
            row = 64'(sz) * by + j + ((sb == SUB_UR) ? 64'd0 : band_h);
            col = 64'(sz) * bx + i + ((sb == SUB_LL) ? 64'd0 : band_w);
            last = (k == lv - 1) && (j == sz - 1) && (i == sz - 1) && (sb == SUB_UR);
            push_pair(offset + sb * sq + j * sz + i, cols * row + col, last);
          end
        end
      end
      offset = (offset + 3 * sq) & 32'h3f;
      sz = sz * 2;
    end
  endfunction

  // register writes, tree requests and result pairs
  always @(posedge clk_i or negedge rst_ni) begin
    addr_pair_t exp_p;
    if (!rst_ni) begin
      levels_q  <= 2'd3;
      columns_q <= 13'd512;
      rows_q    <= 13'd512;
      expected_pairs.delete();
      error_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SCALE_LEVELS:  levels_q  <= pwdata[1:0];
          REG_IMAGE_COLUMNS: columns_q <= pwdata[DimW-1:0];
          REG_IMAGE_ROWS:    rows_q    <= pwdata[DimW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tree_pairs(s_axis_tdata[11:0], s_axis_tdata[23:12]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pairs.size() == 0) begin
          if (error_count < 10)
            $display("unexpected pair: index %0d address %0h last %0b",
                     m_axis_tdata[5:0], m_axis_tdata[29:6], m_axis_tlast);
          error_count++;
        end else begin
          exp_p = expected_pairs.pop_front();
          if (exp_p.tree_index !== m_axis_tdata[5:0] ||
              exp_p.image_address !== m_axis_tdata[29:6] ||
              exp_p.last_pair !== m_axis_tlast) begin
            if (error_count < 10)
              $display("pair mismatch: expected index %0d address %0h last %0b, got %0d %0h %0b",
                       exp_p.tree_index, exp_p.image_address, exp_p.last_pair,
                       m_axis_tdata[5:0], m_axis_tdata[29:6], m_axis_tlast);
            error_count++;
          end
        end
      end
    end
  end

endmodule

@@ bench/wavelet_tree_block_address_gen_top_test.sv @@
module wavelet_tree_block_address_gen_top_test;
  import wtb_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // block_x [11:0], block_y [23:12]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // tree_index [5:0], image_address [29:6], zero [31:30]
  logic        m_axis_tlast;   // last_pair
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned pending;
  int unsigned error_count;

  // current settings, used to aim block coordinates inside the image
  int unsigned cur_levels;
  int unsigned cur_columns;
  int unsigned cur_rows;

  wavelet_tree_block_address_gen_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  tree_address_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .pending_o    (pending),
    .error_count_o(error_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("wavelet_tree_block_address_gen_top_test: done, errors");
    $finish;
  end

  // receiver: ready bursts of varied length, mostly short stalls, a few long ones
  initial begin
    int unsigned r, n;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        m_axis_tready <= 1'b1;
        n = (r < 10) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      end else begin
        m_axis_tready <= 1'b0;
        n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
      end
      repeat (n - 1) @(negedge clk_i);
    end
  end

  // one register write, setup then access
  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop sending and let every outstanding pair drain
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // new settings while idle; junk sets bits above each field
  task automatic set_config(int unsigned lv, int unsigned cols, int unsigned rows, bit junk);
    drain();
    apb_write(REG_SCALE_LEVELS, lv | (junk ? ($urandom << 2) : 0));
    apb_write(REG_IMAGE_COLUMNS, cols | (junk ? ($urandom << DimW) : 0));
    apb_write(REG_IMAGE_ROWS, rows | (junk ? ($urandom << DimW) : 0));
    cur_levels  = lv;
    cur_columns = cols;
    cur_rows    = rows;
  endtask

  // one tree request after a random gap
  task automatic send_item(logic [11:0] bx, logic [11:0] by);
    int unsigned r, gap;
    r = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {by, bx};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // random blocks, most inside the coarse band, some anywhere
  task automatic send_random(int unsigned count);
    int unsigned k, lv, cw, bw, bh;
    logic [11:0] bx, by;
    lv = cur_levels;
    cw = (cur_columns > 4096) ? 4096 : cur_columns;
    bw = cw >> lv;
    bh = cur_rows >> lv;
    if (bw > 4096) bw = 4096;
    if (bh > 4096) bh = 4096;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 75 && bw > 0 && bh > 0) begin
        bx = $urandom_range(0, bw - 1);
        by = $urandom_range(0, bh - 1);
      end else begin
        bx = $urandom;
        by = $urandom;
      end
      send_item(bx, by);
    end
  endtask

  // stimulus and verdict
  initial begin
    int unsigned ph, lv, cols, rows;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cur_levels    = 3;
    cur_columns   = 512;
    cur_rows      = 512;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: corners and alternating bit patterns
    send_item(12'd0, 12'd0);
    send_item(12'hfff, 12'hfff);
    send_item(12'd0, 12'hfff);
    send_item(12'hfff, 12'd0);
    send_item(12'haaa, 12'h555);
    send_item(12'h555, 12'haaa);
    send_item(12'd63, 12'd63);

    // no levels, smallest image
    set_config(0, 8, 8, 0);
    send_item(12'd0, 12'd0);
    send_item(12'hfff, 12'hfff);
    send_item(12'd3, 12'd5);
    send_random(20);

    // one level, largest legal image
    set_config(1, 4096, 4096, 0);
    send_item(12'hfff, 12'hfff);
    send_random(30);

    // columns above the limit saturate, rows at the register maximum
    set_config(2, 8191, 8191, 0);
    send_item(12'hfff, 12'hfff);
    send_random(30);

    // band sizes rounded down
    set_config(3, 100, 37, 0);
    send_random(30);

    // three levels on the smallest image
    set_config(3, 8, 8, 0);
    send_item(12'd0, 12'd0);
    send_random(30);

    // random settings, some with stray upper bits on the bus
    for (ph = 0; ph < 8; ph++) begin
      lv = $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 70) begin
        cols = $urandom_range(1, 128) * 8;
        rows = $urandom_range(1, 128) * 8;
      end else begin
        cols = $urandom_range(8, 8191);
        rows = $urandom_range(8, 8191);
      end
      set_config(lv, cols, rows, $urandom_range(0, 1));
      send_random(28);
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("wavelet_tree_block_address_gen_top_test: done, clean");
    end else begin
      $display("wavelet_tree_block_address_gen_top_test: done, errors");
    end
    $finish;
  end

endmodule
